[src/cos_pkg.sv]
// Shared types and constants for the command operator splitter.
// Holds the record and bundle layouts, operator codes and character codes.
// No dependencies; every other file of the block imports it.
package cos_pkg;

  // Default sizing handed to the top level's parameters.
  localparam int LINE_BYTES_DEF      = 4096;
  localparam int BRACE_DEPTH_MAX_DEF = 255;

  // One byte step never yields more than three records.
  localparam int MAX_RECS    = 3;
  localparam int CNT_W       = 2;
  localparam int QUEUE_DEPTH = 4;
  localparam int QA_W        = 2;

  localparam logic KIND_SEG = 1'b0;
  localparam logic KIND_OP  = 1'b1;

  typedef enum logic [3:0] {
    OP_NONE    = 4'd0,
    OP_REDIR_Q = 4'd1,
    OP_REDIR_T = 4'd2,
    OP_PIPE_GT = 4'd3,
    OP_AND     = 4'd4,
    OP_OR      = 4'd5,
    OP_SEMI    = 4'd6,
    OP_BG      = 4'd7,
    OP_PIPE    = 4'd8
  } op_code_t;

  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_TILDE  = 8'h7E;
  localparam logic [7:0] CH_BAR    = 8'h7C;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NUL    = 8'h00;

  typedef struct packed {
    logic        kind;
    op_code_t    code;
    logic [11:0] offset;
    logic [12:0] length;
    logic        last;
  } rec_t;

  typedef struct packed {
    logic v;
    rec_t r;
  } cand_t;

  // All records caused by one accepted byte, in order, packed from entry 0.
  typedef struct packed {
    logic [CNT_W-1:0]       cnt;
    rec_t [MAX_RECS-1:0]    rec;
  } bundle_t;

endpackage

[src/cos_front.sv]
// Front end of the splitter: accepts bytes, tracks quotes and braces and
// turns each byte into a bundle of segment and operator records.
// Depends on cos_pkg.
module cos_front #(
  parameter int LINE_BYTES      = cos_pkg::LINE_BYTES_DEF,
  parameter int BRACE_DEPTH_MAX = cos_pkg::BRACE_DEPTH_MAX_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_byte,
  input  logic             in_eol,
  output logic             push,
  output cos_pkg::bundle_t push_data,
  input  logic             push_ready
);
  import cos_pkg::*;

  localparam int PW = $clog2(LINE_BYTES + 1);
  localparam int BW = $clog2(BRACE_DEPTH_MAX + 1);
  localparam logic [PW-1:0] LINE_TOP  = PW'(LINE_BYTES);
  localparam logic [BW-1:0] BRACE_TOP = BW'(BRACE_DEPTH_MAX);

  typedef struct packed {
    logic          oq;
    logic          qs;
    logic [BW-1:0] brace;
    logic          ops;
    logic          drop;
    logic [PW-1:0] bp;
    logic [PW-1:0] start;
    logic [PW-1:0] lastv;
    logic          vis;
  } scan_t;

  typedef struct packed {
    scan_t st;
    cand_t seg;
    cand_t opr;
  } jres_t;

  function automatic cand_t mk_seg(scan_t s, logic [PW-1:0] e);
    cand_t       r;
    logic [PW:0] len;
    r = '0;
    len = s.vis ? ({1'b0, s.lastv} - {1'b0, s.start} + (PW+1)'(1)) : (PW+1)'(1);
    r.v        = (e > s.start);
    r.r.kind   = KIND_SEG;
    r.r.code   = OP_NONE;
    r.r.offset = 12'(s.start);
    r.r.length = 13'(len);
    return r;
  endfunction

  // Judges one byte against its successor.
  function automatic jres_t judge(scan_t s, logic [7:0] c, logic [7:0] nx);
    jres_t         r;
    logic [PW-1:0] pos;
    logic          sh;
    op_code_t      code;
    logic          two;
    logic [PW:0]   nstart;
    r    = '0;
    r.st = s;
    pos  = s.bp;
    sh   = 1'b0;
    code = OP_NONE;
    two  = 1'b0;
    if (s.bp < LINE_TOP) r.st.bp = s.bp + 1'b1;
    if (s.drop) begin
      r.st.drop = 1'b0;
    end else begin
      if (!s.oq && (c == CH_DQUOTE || c == CH_SQUOTE)) begin
        r.st.oq = 1'b1;
        r.st.qs = (c == CH_SQUOTE);
        sh = 1'b1;
      end else if (s.oq) begin
        if (c == (s.qs ? CH_SQUOTE : CH_DQUOTE)) begin
          r.st.oq = 1'b0;
          r.st.qs = 1'b0;
        end
        sh = 1'b1;
      end else if (c == CH_LBRACE) begin
        if (s.brace < BRACE_TOP) r.st.brace = s.brace + 1'b1;
        sh = 1'b1;
      end else if (c == CH_RBRACE) begin
        if (s.brace != '0) r.st.brace = s.brace - 1'b1;
        sh = 1'b1;
      end else if (s.brace != '0) begin
        sh = 1'b1;
      end

      if (!sh) begin
        if (c == CH_QMARK && nx == CH_GT) begin
          code = OP_REDIR_Q; two = 1'b1;
        end else if (c == CH_TILDE && nx == CH_GT) begin
          code = OP_REDIR_T; two = 1'b1;
        end else if (c == CH_BAR && nx == CH_GT) begin
          code = OP_PIPE_GT; two = 1'b1;
        end else if (c == CH_AMP && nx == CH_AMP) begin
          code = OP_AND; two = 1'b1;
        end else if (c == CH_BAR && nx == CH_BAR) begin
          code = OP_OR; two = 1'b1;
        end else if (c == CH_SEMI) begin
          code = OP_SEMI;
        end else if (c == CH_AMP) begin
          code = OP_BG;
        end else if (s.ops && c == CH_BAR) begin
          code = OP_PIPE;
        end
      end

      if (code != OP_NONE) begin
        r.st.ops    = 1'b1;
        r.seg       = mk_seg(s, pos);
        r.opr.v     = 1'b1;
        r.opr.r     = '0;
        r.opr.r.kind = KIND_OP;
        r.opr.r.code = code;
        r.st.drop   = two;
        nstart      = {1'b0, pos} + (two ? (PW+1)'(2) : (PW+1)'(1));
        r.st.start  = (nstart > {1'b0, LINE_TOP}) ? LINE_TOP : nstart[PW-1:0];
        r.st.vis    = 1'b0;
        r.st.lastv  = '0;
      end else if (c != CH_SPACE && c != CH_TAB && pos < LINE_TOP) begin
        r.st.lastv = pos;
        r.st.vis   = 1'b1;
      end
    end
    return r;
  endfunction

  scan_t      st_r, st_nxt;
  logic [7:0] held_r, held_nxt;
  logic       held_vld_r, held_vld_nxt;

  jres_t      j1, j2;
  cand_t      fin;
  cand_t [4:0] cands;
  bundle_t    bnd;
  logic [2:0] n;
  logic       acc;

  assign in_ready = push_ready;
  assign acc      = in_valid && in_ready;

  always_comb begin
    if (held_vld_r) begin
      j1 = judge(st_r, held_r, in_byte);
    end else begin
      j1    = '0;
      j1.st = st_r;
    end
    j2  = judge(j1.st, in_byte, CH_NUL);
    fin = mk_seg(j2.st, j2.st.bp);

    cands[0] = j1.seg;
    cands[1] = j1.opr;
    cands[2] = in_eol ? j2.seg : cand_t'('0);
    cands[3] = in_eol ? j2.opr : cand_t'('0);
    cands[4] = in_eol ? fin    : cand_t'('0);

    bnd = '0;
    n   = '0;
    for (int i = 0; i < 5; i++) begin
      if (cands[i].v) begin
        if (n < 3'(MAX_RECS)) bnd.rec[n[1:0]] = cands[i].r;
        n = n + 3'd1;
      end
    end
    bnd.cnt = n[CNT_W-1:0];
    if (in_eol && n != '0) bnd.rec[n[1:0] - 2'd1].last = 1'b1;

    st_nxt       = st_r;
    held_nxt     = held_r;
    held_vld_nxt = held_vld_r;
    if (acc) begin
      st_nxt       = in_eol ? scan_t'('0) : j1.st;
      held_nxt     = in_eol ? 8'h00 : in_byte;
      held_vld_nxt = !in_eol;
    end
  end

  assign push      = acc && (bnd.cnt != '0);
  assign push_data = bnd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= '0;
      held_r     <= '0;
      held_vld_r <= 1'b0;
    end else begin
      st_r       <= st_nxt;
      held_r     <= held_nxt;
      held_vld_r <= held_vld_nxt;
    end
  end

`ifndef SYNTHESIS
  // No byte is held across a line boundary.
  a_eol_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_eol) |=> (!held_vld_r && st_r == '0))
    else $error("line state not cleared after end of line");
  // A quote state without an open quote never survives.
  a_quote_flag: assert property (@(posedge clk) disable iff (!rst_n)
    !st_r.oq |-> !st_r.qs)
    else $error("single-quote flag set without open quote");
  // Bundles never overflow the record slots.
  a_bundle_fits: assert property (@(posedge clk) disable iff (!rst_n)
    acc |-> (n <= 3'(MAX_RECS)))
    else $error("more records than bundle slots");
`endif

endmodule

[src/cos_fifo.sv]
// Short bundle queue between the front end and the back end.
// Lets either side stall on its own. Depends on cos_pkg.
module cos_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  cos_pkg::bundle_t push_data,
  output logic             push_ready,
  input  logic             pop,
  output cos_pkg::bundle_t pop_data,
  output logic             pop_valid
);
  import cos_pkg::*;

  bundle_t         mem_r [QUEUE_DEPTH];
  logic [QA_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QA_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QA_W:0]   cnt_r, cnt_nxt;

  assign push_ready = (cnt_r != (QA_W+1)'(QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (QA_W+1)'(push) - (QA_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> push_ready)
    else $error("push into a full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> pop_valid)
    else $error("pop from an empty queue");
  a_ptr_agree: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with count");
`endif

endmodule

[src/cos_back.sv]
// Back end of the splitter: takes bundles from the queue and delivers their
// records one per cycle while out_ready allows, through an output register. Depends on cos_pkg.
module cos_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  cos_pkg::bundle_t q_data,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output cos_pkg::rec_t    out_rec
);
  import cos_pkg::*;

  bundle_t          bnd_r, bnd_nxt;
  logic             bnd_vld_r, bnd_vld_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  rec_t             out_rec_r, out_rec_nxt;
  logic             out_vld_r, out_vld_nxt;
  logic             out_free;
  logic             done;

  assign out_free = !out_vld_r || out_ready;
  assign done     = bnd_vld_r && out_free && (idx_r == bnd_r.cnt - 1'b1);
  assign q_pop    = q_valid && (!bnd_vld_r || done);

  always_comb begin
    bnd_nxt     = bnd_r;
    bnd_vld_nxt = bnd_vld_r;
    idx_nxt     = idx_r;
    out_rec_nxt = out_rec_r;
    out_vld_nxt = out_vld_r;
    if (out_free) begin
      out_vld_nxt = bnd_vld_r;
      if (bnd_vld_r) begin
        out_rec_nxt = bnd_r.rec[idx_r];
        idx_nxt     = idx_r + 1'b1;
      end
    end
    if (done) bnd_vld_nxt = 1'b0;
    if (q_pop) begin
      bnd_nxt     = q_data;
      bnd_vld_nxt = 1'b1;
      idx_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bnd_vld_r <= 1'b0;
      idx_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      bnd_vld_r <= bnd_vld_nxt;
      idx_r     <= idx_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bnd_r     <= bnd_nxt;
    out_rec_r <= out_rec_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_rec   = out_rec_r;

`ifndef SYNTHESIS
  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    bnd_vld_r |-> (bnd_r.cnt != '0 && idx_r < bnd_r.cnt))
    else $error("record index outside loaded bundle");
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (bnd_vld_r && idx_r != bnd_r.cnt - 1'b1) |-> !bnd_r.rec[idx_r].last)
    else $error("end-of-line record not at bundle end");
`endif

endmodule

[src/command_operator_splitter_top.sv]
// Top level of the command operator splitter.
// Instantiates cos_front, cos_fifo and cos_back; depends on cos_pkg.
//
// Usage: one byte of a command line per request enters on the in_ channel,
// in_tlast marking the final byte of the line. For each line the block
// returns command segments (offset and trimmed length) and operator tokens
// on the out_ channel; out_tuser tells the two apart and out_tlast flags
// the final record of the line.
// A byte is judged only when its successor arrives (or at end of line), so
// the records of a byte show up with the next request. From the accepting
// edge, the first record passes through the bundle queue, the back end's
// bundle register and the output register before it appears on out_tvalid.
// Throughput: one byte per cycle as long as each byte yields at most one
// record and out_tready stays high; a byte that yields more records (up to
// three, at end of line) holds the output longer, since the output register
// delivers one record per cycle. The four-entry bundle queue absorbs such bursts.
// When the receiver stalls, the output register holds its record, the queue
// fills and in_tready drops once four bundles wait.
// Reset (rst_n low at a clock edge) clears the line state, the queue and
// the output; no clearing pass is needed.
module command_operator_splitter_top #(
  parameter int LINE_BYTES      = cos_pkg::LINE_BYTES_DEF,
  parameter int BRACE_DEPTH_MAX = cos_pkg::BRACE_DEPTH_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_byte
  input  logic        in_tlast,   // end_of_line
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [3:0] operator_code, [15:4] segment_offset,
                                  // [28:16] segment_length, [31:29] zero
  output logic        out_tuser,  // record_kind: 0 segment, 1 operator
  output logic        out_tlast   // last_of_line
);
  import cos_pkg::*;

  logic    push, push_ready, q_valid, q_pop;
  bundle_t push_data, q_data;
  rec_t    rec;

  // Front end: classifies bytes into record bundles.
  cos_front #(
    .LINE_BYTES      (LINE_BYTES),
    .BRACE_DEPTH_MAX (BRACE_DEPTH_MAX)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_byte    (in_tdata),
    .in_eol     (in_tlast),
    .push       (push),
    .push_data  (push_data),
    .push_ready (push_ready)
  );

  // Bundle queue decoupling the two halves.
  cos_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop        (q_pop),
    .pop_data   (q_data),
    .pop_valid  (q_valid)
  );

  // Back end: serializes bundles into single records.
  cos_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_rec   (rec)
  );

  // Pack the record fields onto the stream ports.
  assign out_tdata = {3'b000, rec.length, rec.offset, rec.code};
  assign out_tuser = rec.kind;
  assign out_tlast = rec.last;

endmodule

[bench/command_operator_splitter_top_tb.sv]
// Self-checking bench for command_operator_splitter_top: it streams command lines in and
// checks every segment and operator record against an in-bench line splitter.
// Depends on cos_pkg and the RTL under src; it needs no other file.
module command_operator_splitter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cos_pkg::*;

  localparam int LINE_LEN     = 4096;
  localparam int DEPTH_CAP    = 255;
  localparam int RANDOM_ITEMS = 250;
  localparam int QUIET_LIMIT  = 2000;  // cycles with no request moving on either side
  localparam int HOLD_CYCLES  = 300;   // long receiver hold-off that backs up the block
  localparam int TAIL_CYCLES  = 12;

  typedef struct {
    logic [7:0] chr;
    logic       eol;
  } line_byte_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  command_operator_splitter_top #(
    .LINE_BYTES     (LINE_LEN),
    .BRACE_DEPTH_MAX(DEPTH_CAP)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Bytes waiting to be offered, and the line under construction.
  line_byte_t line_bytes_q[$];
  logic [7:0] line_buf[$];

  // Records the splitter must still produce, oldest first.
  rec_t awaited_records[$];
  rec_t step_recs[$];

  // Line splitter state, cleared after every line end.
  logic       in_quote;
  logic       quote_single;
  logic       op_seen;
  logic       held_ok;
  logic       skip_next;
  logic       vis_seen;
  logic [7:0] held_chr;
  int         depth;
  int         pos_ctr;
  int         seg_start;
  int         last_vis;

  int mismatch_count = 0;
  int checked_count  = 0;
  int quiet_cycles   = 0;
  int sent_count     = 0;
  int taken_count    = 0;
  int send_gap       = 0;
  int hold_left      = 0;
  bit in_taken       = 1'b0;
  bit out_taken      = 1'b0;

  // ---------------------------------------------------------------------------
  // Line splitter
  // ---------------------------------------------------------------------------

  function automatic void clear_line_state();
    in_quote     = 1'b0;
    quote_single = 1'b0;
    op_seen      = 1'b0;
    held_ok      = 1'b0;
    skip_next    = 1'b0;
    vis_seen     = 1'b0;
    held_chr     = 8'h00;
    depth        = 0;
    pos_ctr      = 0;
    seg_start    = 0;
    last_vis     = 0;
  endfunction

  function automatic void add_record(logic kind, op_code_t code, int off, int len);
    rec_t r;
    r.kind   = kind;
    r.code   = code;
    r.offset = off[11:0];
    r.length = len[12:0];
    r.last   = 1'b0;
    step_recs.push_back(r);
  endfunction

  // A segment always keeps its first byte, even when it is all blanks.
  function automatic void close_segment(int end_at);
    if (end_at <= seg_start) return;
    add_record(KIND_SEG, OP_NONE, seg_start, vis_seen ? last_vis - seg_start + 1 : 1);
  endfunction

  // Judges byte c now that its successor nxt is known.
  function automatic void judge_char(logic [7:0] c, logic [7:0] nxt);
    int       at;
    int       oplen;
    op_code_t code;
    logic     guarded;
    at      = pos_ctr;
    oplen   = 0;
    code    = OP_NONE;
    guarded = 1'b0;
    if (pos_ctr < LINE_LEN) pos_ctr++;
    if (skip_next) begin
      skip_next = 1'b0;
      return;
    end
    if (!in_quote && (c == CH_DQUOTE || c == CH_SQUOTE)) begin
      in_quote     = 1'b1;
      quote_single = (c == CH_SQUOTE);
      guarded      = 1'b1;
    end else if (in_quote) begin
      if (c == (quote_single ? CH_SQUOTE : CH_DQUOTE)) begin
        in_quote     = 1'b0;
        quote_single = 1'b0;
      end
      guarded = 1'b1;
    end else if (c == CH_LBRACE) begin
      if (depth < DEPTH_CAP) depth++;
      guarded = 1'b1;
    end else if (c == CH_RBRACE) begin
      if (depth > 0) depth--;
      guarded = 1'b1;
    end else if (depth > 0) begin
      guarded = 1'b1;
    end
    if (!guarded) begin
      if (c == CH_QMARK && nxt == CH_GT) begin
        code = OP_REDIR_Q; oplen = 2;
      end else if (c == CH_TILDE && nxt == CH_GT) begin
        code = OP_REDIR_T; oplen = 2;
      end else if (c == CH_BAR && nxt == CH_GT) begin
        code = OP_PIPE_GT; oplen = 2;
      end else if (c == CH_AMP && nxt == CH_AMP) begin
        code = OP_AND; oplen = 2;
      end else if (c == CH_BAR && nxt == CH_BAR) begin
        code = OP_OR; oplen = 2;
      end else if (c == CH_SEMI) begin
        code = OP_SEMI; oplen = 1;
      end else if (c == CH_AMP) begin
        code = OP_BG; oplen = 1;
      end else if (op_seen && c == CH_BAR) begin
        code = OP_PIPE; oplen = 1;
      end
    end
    if (code != OP_NONE) begin
      op_seen = 1'b1;
      close_segment(at);
      add_record(KIND_OP, code, 0, 0);
      if (oplen == 2) skip_next = 1'b1;
      seg_start = (at + oplen > LINE_LEN) ? LINE_LEN : at + oplen;
      vis_seen  = 1'b0;
      last_vis  = 0;
      return;
    end
    if (c != CH_SPACE && c != CH_TAB && at < LINE_LEN) begin
      last_vis = at;
      vis_seen = 1'b1;
    end
  endfunction

  // One accepted request: the held byte is judged, and at a line end the
  // final byte too, then the closing segment is flushed.
  function automatic void split_step(logic [7:0] c, logic eol);
    rec_t r;
    step_recs.delete();
    if (held_ok) judge_char(held_chr, c);
    if (eol) begin
      judge_char(c, CH_NUL);
      close_segment(pos_ctr);
      if (step_recs.size() > 0) begin
        r      = step_recs.pop_back();
        r.last = 1'b1;
        step_recs.push_back(r);
      end
      clear_line_state();
    end else begin
      held_chr = c;
      held_ok  = 1'b1;
    end
    foreach (step_recs[i]) awaited_records.push_back(step_recs[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Line construction
  // ---------------------------------------------------------------------------

  function automatic void buf_text(string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endfunction

  function automatic void buf_pick(string chars, int count);
    repeat (count) line_buf.push_back(chars[$urandom_range(0, chars.len() - 1)]);
  endfunction

  // Moves the line under construction to the send queue, tlast on its last byte.
  function automatic void flush_line();
    line_byte_t b;
    foreach (line_buf[i]) begin
      b.chr = line_buf[i];
      b.eol = (i == line_buf.size() - 1);
      line_bytes_q.push_back(b);
    end
    line_buf.delete();
  endfunction

  // Mostly shell-like lines with random words, blanks, operators, quotes and
  // brace groups; one line in ten is raw byte noise.
  function automatic void add_random_line();
    logic [7:0] q;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 12)) line_buf.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 8)) begin
        case ($urandom_range(0, 9))
          0, 1, 2: buf_pick("abcdefgxyz0189_-./=", $urandom_range(1, 6));
          3:       buf_pick(" \t", $urandom_range(1, 3));
          4, 5, 6: begin
            case ($urandom_range(0, 7))
              0:       buf_text("?>");
              1:       buf_text("~>");
              2:       buf_text("|>");
              3:       buf_text("&&");
              4:       buf_text("||");
              5:       buf_text(";");
              6:       buf_text("&");
              default: buf_text("|");
            endcase
          end
          7: begin
            q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
            line_buf.push_back(q);
            buf_pick("ab ;&|>{}'\"", $urandom_range(1, 5));
            if ($urandom_range(0, 7) != 0) line_buf.push_back(q);
          end
          8: begin
            line_buf.push_back(CH_LBRACE);
            buf_pick("ab ;&|>{'", $urandom_range(1, 5));
            repeat ($urandom_range(0, 2)) line_buf.push_back(CH_RBRACE);
          end
          default: buf_pick("?~>|&{}'\"", 1);
        endcase
      end
    end
    flush_line();
  endfunction

  function automatic int draw_gap(int count, int period);
    // Idle style changes every period requests: none, uniform, or rare bursts.
    case ((count / period) % 3)
      0:       return 0;
      1:       return $urandom_range(0, 10);
      default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] record %0d: %s got 0x%0h, expected 0x%0h",
             $time, checked_count, what, got, want);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Input driver: offers the head of the send queue, changing at the falling
  // edge. A request that was accepted at the last rising edge is popped here,
  // and then a fresh idle gap is drawn. With a gap of zero tvalid simply stays
  // high, so back-to-back requests never toggle it within one step.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    logic nxt_valid;
    if (rst_n) begin
      nxt_valid = in_tvalid;
      if (in_tvalid && in_taken) begin
        in_taken = 1'b0;
        void'(line_bytes_q.pop_front());
        sent_count++;
        send_gap  = draw_gap(sent_count, 50);
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (send_gap > 0) send_gap--;
        else if (line_bytes_q.size() > 0) nxt_valid = 1'b1;
      end
      in_tvalid <= nxt_valid;
      if (nxt_valid) begin
        in_tdata <= line_bytes_q[0].chr;
        in_tlast <= line_bytes_q[0].eol;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output receiver: after each accepted record it drops tready for a drawn
  // number of cycles. Twice in the run it holds off far longer, so the
  // bundle queue fills and the block has to push back on its input while the
  // driver keeps a request waiting.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_taken) begin
        out_taken = 1'b0;
        taken_count++;
        hold_left = draw_gap(taken_count, 37);
        if (taken_count == 25 || taken_count == 90) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: at each rising edge, an accepted input request advances the
  // splitter and queues its records; an accepted output record is checked
  // field by field against the oldest queued one. A watchdog ends the run
  // when no request has moved for too long.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    rec_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        split_step(in_tdata, in_tlast);
        in_taken = 1'b1;
      end
      if (out_tvalid && out_tready) begin
        out_taken = 1'b1;
        if (awaited_records.size() == 0) begin
          report_mismatch("record with none expected", out_tdata, 32'h0);
        end else begin
          want = awaited_records.pop_front();
          if (out_tuser !== want.kind)
            report_mismatch("record kind", out_tuser, want.kind);
          if (out_tdata[3:0] !== want.code)
            report_mismatch("operator code", out_tdata[3:0], want.code);
          if (out_tdata[15:4] !== want.offset)
            report_mismatch("segment offset", out_tdata[15:4], want.offset);
          if (out_tdata[28:16] !== want.length)
            report_mismatch("segment length", out_tdata[28:16], want.length);
          if (out_tdata[31:29] !== 3'b000)
            report_mismatch("padding bits", out_tdata[31:29], 32'h0);
          if (out_tlast !== want.last)
            report_mismatch("last of line", out_tlast, want.last);
        end
        checked_count++;
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[%0t] timeout: no request moved for %0d cycles", $time, QUIET_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run. The whole send queue is built at time zero; the
  // driver drains it once reset has been released.
  // ---------------------------------------------------------------------------
  initial begin
    int base;
    clear_line_state();

    // All two-byte operators in a row, each between plain words.
    buf_text("a?>b~>c|>d&&e||f");
    flush_line();
    // Leading semicolon opens no empty segment; a bare pipe after an
    // operator; a trailing tab is trimmed; a final ampersand stands alone.
    buf_text(";x|y\t&");
    flush_line();
    // Unmatched closing brace, a double quote holding a single quote, a
    // brace group hiding a pipe, and a question mark at the line end.
    buf_text("}\"&'\"{|}?");
    flush_line();
    // Leading blank kept, zero byte as data, a pipe before any operator is
    // plain data, and a brace left open at the line end.
    buf_text(" ");
    line_buf.push_back(CH_NUL);
    buf_text("|{;");
    flush_line();
    // Quote left open at the line end.
    buf_text("'x;");
    flush_line();
    // A blank-only segment keeps its first byte; a line of one operator.
    buf_text(" ;");
    flush_line();
    buf_text("&");
    flush_line();

    // Nested braces hide an operator; the extra closer is ignored at depth
    // zero, so the final && is an operator.
    buf_text("{{;}}}a&&z");
    flush_line();

    base = line_bytes_q.size();
    while (line_bytes_q.size() - base < RANDOM_ITEMS) add_random_line();
    buf_text("end;ok");
    flush_line();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (line_bytes_q.size() != 0 || awaited_records.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (mismatch_count == 0 && awaited_records.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
